// ===== hw/rtl/flh_pkg.sv =====
package flh_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_FAULT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_POINTS_W   = 3'd0;
  localparam logic [2:0] CFG_POINTS_H   = 3'd1;
  localparam logic [2:0] CFG_SPACING    = 3'd2;
  localparam logic [2:0] CFG_BASE       = 3'd3;
  localparam logic [2:0] CFG_DISP_START = 3'd4;
  localparam logic [2:0] CFG_DISP_END   = 3'd5;
  localparam logic [2:0] CFG_ITERATIONS = 3'd6;

  // Fixed-point constants: pi/2 in Q16.16, the table phase span (pi*pi/4) and one in Q4.28.
  localparam logic [63:0] HALF_PI_Q16   = 64'd102944;
  localparam logic [63:0] PHASE_SPAN_Q28 = 64'd662337940;
  localparam logic [63:0] ONE_Q28       = 64'd268435456;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] line_sin;
    logic [15:0] line_cos;
    logic [31:0] line_offset;
    logic [11:0] read_index;
  } item_t;

  typedef struct packed {
    logic [6:0]  points_w;
    logic [6:0]  points_h;
    logic [24:0] point_spacing;
    logic [31:0] base_height;
    logic [31:0] disp_start;
    logic [31:0] disp_end;
    logic [15:0] iteration_count;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] height;
    logic [15:0] faults;
  } result_t;

  // Taylor series sine in Q4.28, evaluated at elaboration to fill the phase table.
  function automatic logic [63:0] sine_q28(input logic [63:0] theta);
    logic [63:0] t2;
    logic [63:0] term;
    logic signed [63:0] acc;
    t2 = (theta * theta) >> 28;
    term = theta;
    acc = $signed(theta);
    term = ((term * t2) >> 28) / 64'd6;   acc = acc - $signed(term);
    term = ((term * t2) >> 28) / 64'd20;  acc = acc + $signed(term);
    term = ((term * t2) >> 28) / 64'd42;  acc = acc - $signed(term);
    term = ((term * t2) >> 28) / 64'd72;  acc = acc + $signed(term);
    term = ((term * t2) >> 28) / 64'd110; acc = acc - $signed(term);
    term = ((term * t2) >> 28) / 64'd156; acc = acc + $signed(term);
    term = ((term * t2) >> 28) / 64'd210; acc = acc - $signed(term);
    term = ((term * t2) >> 28) / 64'd272; acc = acc + $signed(term);
    term = ((term * t2) >> 28) / 64'd342; acc = acc - $signed(term);
    term = ((term * t2) >> 28) / 64'd420; acc = acc + $signed(term);
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > $signed(ONE_Q28)) begin
      acc = $signed(ONE_Q28);
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/flh_front.sv =====
module flh_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     in_operation,
  input  logic [15:0]    in_line_sin,
  input  logic [15:0]    in_line_cos,
  input  logic [31:0]    in_line_offset,
  input  logic [11:0]    in_read_index,
  input  logic           item_pop,
  output logic           item_valid,
  output flh_pkg::item_t item
);

  flh_pkg::item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  flh_pkg::item_t incoming;

  // Classify the incoming operation; unknown codes pass through to be echoed.
  always_comb begin
    incoming.op          = in_operation;
    incoming.line_sin    = in_line_sin;
    incoming.line_cos    = in_line_cos;
    incoming.line_offset = in_line_offset;
    incoming.read_index  = in_read_index;
    case (in_operation)
      flh_pkg::OP_CLEAR, flh_pkg::OP_READ: begin
        incoming.line_sin    = '0;
        incoming.line_cos    = '0;
        incoming.line_offset = '0;
      end
      default: begin
      end
    endcase
  end

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = slot_r[rd_ptr_r];

  // Queue pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = item_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, item_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage takes each accepted transfer.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= incoming;
    end
  end

endmodule

// ===== hw/rtl/flh_div.sv =====
module flh_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [47:0] quotient
);

  logic [15:0] rem_r;
  logic [47:0] quo_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [16:0] shifted;
  logic [16:0] trial;

  // One restoring step per cycle, most significant bit first.
  assign shifted  = {rem_r, quo_r[47]};
  assign trial    = shifted - {1'b0, divisor};
  assign busy     = busy_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd48;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 6'd1;
      busy_r <= (cnt_r != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      if (!trial[16]) begin
        rem_r <= trial[15:0];
        quo_r <= {quo_r[46:0], 1'b1};
      end else begin
        rem_r <= shifted[15:0];
        quo_r <= {quo_r[46:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/flh_back.sv =====
module flh_back #(
  parameter int MAX_POINTS_W     = 64,
  parameter int MAX_POINTS_H     = 64,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  flh_pkg::cfg_t    cfg,
  input  logic             item_valid,
  input  flh_pkg::item_t   item,
  output logic             item_pop,
  output flh_pkg::result_t res
);

  localparam int STORE = MAX_POINTS_W * MAX_POINTS_H;
  localparam int AW    = $clog2(STORE);
  localparam int WW    = $clog2(MAX_POINTS_W + 1);
  localparam int HW    = $clog2(MAX_POINTS_H + 1);
  localparam int KW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [63:0] RECIP = (64'd1 << 48) / flh_pkg::HALF_PI_Q16 + 64'd1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_RD2   = 4'd3;
  localparam logic [3:0] ST_F0    = 4'd4;
  localparam logic [3:0] ST_F1    = 4'd5;
  localparam logic [3:0] ST_F2    = 4'd6;
  localparam logic [3:0] ST_RUN   = 4'd7;
  localparam logic [3:0] ST_DRAIN = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [15:0]      fault_cnt_r, fault_cnt_nxt;
  flh_pkg::result_t res_r, res_nxt;
  flh_pkg::item_t   cur_r;
  logic [AW-1:0]    addr_r;
  logic [AW-1:0]    total_m1_r;
  logic [WW-1:0]    w_r;
  logic [WW-1:0]    col_r;
  logic [33:0]      half_w_r, half_h_r;
  logic signed [41:0] ssp_r, csp_r;
  logic signed [49:0] sx0_r, cz0_r, acc_r, row_acc_r;
  logic [47:0]      num_mag_r;
  logic             num_neg_r, use_div_r;
  logic signed [31:0] disp_r;
  logic             rd_ok_r;
  logic             clr_we, run_issue, div_start, div_busy;
  logic [47:0]      div_quo;

  logic [28:0] sine_tab [SINE_TABLE_DEPTH + 1];

  // Phase table of sin(k*pi*pi/(4*depth)) in Q4.28.
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [63:0] THETA = (flh_pkg::PHASE_SPAN_Q28 * 64'(k)) / SINE_TABLE_DEPTH;
    assign sine_tab[k] = 29'(flh_pkg::sine_q28(THETA));
  end

  // Clamped grid sizes and the effective iteration count.
  logic [31:0] w_ext, h_ext;
  logic [WW-1:0] w_c;
  logic [HW-1:0] h_c;
  logic [15:0]   n_eff;
  logic signed [32:0] disp_diff;
  logic signed [49:0] num_full;
  logic signed [33:0] disp_sum;
  logic signed [33:0] quo_signed;

  always_comb begin
    w_ext = 32'(cfg.points_w);
    h_ext = 32'(cfg.points_h);
    if (w_ext < 32'd2) begin
      w_c = WW'(2);
    end else if (w_ext > 32'(MAX_POINTS_W)) begin
      w_c = WW'(MAX_POINTS_W);
    end else begin
      w_c = WW'(w_ext);
    end
    if (h_ext < 32'd2) begin
      h_c = HW'(2);
    end else if (h_ext > 32'(MAX_POINTS_H)) begin
      h_c = HW'(MAX_POINTS_H);
    end else begin
      h_c = HW'(h_ext);
    end
    n_eff      = (cfg.iteration_count == 16'd0) ? 16'd1 : cfg.iteration_count;
    disp_diff  = 33'($signed(cfg.disp_end)) - 33'($signed(cfg.disp_start));
    num_full   = 50'(disp_diff * $signed({1'b0, fault_cnt_r}));
    quo_signed = num_neg_r ? -$signed({1'b0, div_quo[32:0]})
                           : $signed({1'b0, div_quo[32:0]});
    disp_sum   = 34'($signed(cfg.disp_start)) + quo_signed;
  end

  flh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_mag_r),
    .divisor  (n_eff),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Vertex pipeline registers.
  logic               a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r;
  logic signed [49:0] a_acc_r;
  logic [AW-1:0]      a_idx_r, b_idx_r, c_idx_r, d_idx_r, e_idx_r;
  logic               b_neg_r, b_beyond_r, c_neg_r, c_beyond_r;
  logic [31:0]        b_p_r;
  logic [63:0]        c_prod_r;
  logic [31:0]        c_h_r, d_h_r, e_h_r;
  logic signed [29:0] d_f_r;
  logic signed [61:0] e_prod_r;
  logic [31:0]        rd_data_r;
  logic [31:0]        mem [STORE];

  // Sequencer: one item at a time from the queue.
  always_comb begin
    state_nxt     = state_r;
    fault_cnt_nxt = fault_cnt_r;
    res_nxt       = '0;
    item_pop      = 1'b0;
    div_start     = 1'b0;
    run_issue     = 1'b0;
    clr_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          case (item.op)
            flh_pkg::OP_CLEAR: state_nxt = ST_CLR;
            flh_pkg::OP_FAULT: state_nxt = ST_F0;
            flh_pkg::OP_READ:  state_nxt = ST_RD;
            default: begin
              res_nxt.valid  = 1'b1;
              res_nxt.kind   = item.op;
              res_nxt.faults = fault_cnt_r;
            end
          endcase
        end
      end
      ST_CLR: begin
        clr_we = 1'b1;
        if (addr_r == AW'(STORE - 1)) begin
          fault_cnt_nxt  = '0;
          res_nxt.valid  = 1'b1;
          res_nxt.kind   = flh_pkg::OP_CLEAR;
          res_nxt.faults = '0;
          state_nxt      = ST_IDLE;
        end
      end
      ST_RD: state_nxt = ST_RD2;
      ST_RD2: begin
        res_nxt.valid  = 1'b1;
        res_nxt.kind   = flh_pkg::OP_READ;
        res_nxt.height = rd_ok_r ? rd_data_r : '0;
        res_nxt.faults = fault_cnt_r;
        state_nxt      = ST_IDLE;
      end
      ST_F0: state_nxt = ST_F1;
      ST_F1: begin
        div_start = use_div_r;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        if (!div_busy) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        run_issue = 1'b1;
        if (addr_r == total_m1_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(a_vld_r || b_vld_r || c_vld_r || d_vld_r || e_vld_r)) begin
          fault_cnt_nxt  = (fault_cnt_r == 16'hFFFF) ? fault_cnt_r : fault_cnt_r + 16'd1;
          res_nxt.valid  = 1'b1;
          res_nxt.kind   = flh_pkg::OP_FAULT;
          res_nxt.faults = fault_cnt_nxt;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign res = res_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fault_cnt_r <= '0;
      res_r       <= '0;
      addr_r      <= '0;
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      e_vld_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      res_r       <= res_nxt;
      if (state_r == ST_IDLE || state_r == ST_F2) begin
        addr_r <= '0;
      end else if (clr_we || run_issue) begin
        addr_r <= addr_r + AW'(1);
      end
      a_vld_r <= run_issue;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
    end
  end

  // Fault setup and the walk over the grid.
  always_ff @(posedge clk) begin
    if (item_pop) begin
      cur_r <= item;
    end
    case (state_r)
      ST_RD: rd_ok_r <= (32'(cur_r.read_index) < 32'(STORE));
      ST_F0: begin
        w_r        <= w_c;
        half_w_r   <= (34'(w_c) * 34'(cfg.point_spacing)) >> 1;
        half_h_r   <= (34'(h_c) * 34'(cfg.point_spacing)) >> 1;
        ssp_r      <= 42'($signed(cur_r.line_sin) * $signed({1'b0, cfg.point_spacing}));
        csp_r      <= 42'($signed(cur_r.line_cos) * $signed({1'b0, cfg.point_spacing}));
        total_m1_r <= AW'(32'(w_c) * 32'(h_c) - 32'd1);
        num_neg_r  <= num_full[49];
        num_mag_r  <= num_full[49] ? 48'(-num_full) : 48'(num_full);
        use_div_r  <= (fault_cnt_r < n_eff);
      end
      ST_F1: begin
        sx0_r <= 50'($signed(cur_r.line_sin) * $signed({1'b0, half_w_r}));
        cz0_r <= 50'($signed(cur_r.line_cos) * $signed({1'b0, half_h_r}));
      end
      ST_F2: begin
        acc_r     <= -sx0_r - cz0_r;
        row_acc_r <= -sx0_r - cz0_r;
        col_r     <= '0;
        disp_r    <= use_div_r ? 32'(disp_sum) : $signed(cfg.disp_end);
      end
      ST_RUN: begin
        if (col_r == w_r - WW'(1)) begin
          col_r     <= '0;
          row_acc_r <= row_acc_r + 50'(csp_r);
          acc_r     <= row_acc_r + 50'(csp_r);
        end else begin
          col_r <= col_r + WW'(1);
          acc_r <= acc_r + 50'(ssp_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Per-vertex datapath: distance, phase index, sine, scaled increment.
  logic signed [37:0] vdist;
  logic [37:0]        mag;
  logic [15:0]        k_raw;
  logic [KW-1:0]      k_sel;
  logic signed [29:0] f_mag;
  logic signed [33:0] delta;
  logic signed [34:0] new_h;
  logic [31:0]        new_h_sat;

  always_comb begin
    vdist = 38'($signed(a_acc_r[49:14])) - 38'($signed(cur_r.line_offset));
    mag   = vdist[37] ? 38'(-vdist) : 38'(vdist);
    k_raw = c_prod_r[63:48];
    k_sel = (k_raw > 16'(SINE_TABLE_DEPTH)) ? KW'(SINE_TABLE_DEPTH) : KW'(k_raw);
    f_mag = c_beyond_r ? 30'(flh_pkg::ONE_Q28) : $signed({1'b0, sine_tab[k_sel]});
    delta = 34'(e_prod_r >>> 28);
    new_h = 35'($signed(e_h_r)) + 35'(delta);
    if (new_h > 35'sd2147483647) begin
      new_h_sat = 32'h7FFF_FFFF;
    end else if (new_h < -35'sd2147483648) begin
      new_h_sat = 32'h8000_0000;
    end else begin
      new_h_sat = 32'(new_h);
    end
  end

  always_ff @(posedge clk) begin
    a_acc_r    <= acc_r;
    a_idx_r    <= addr_r;
    b_idx_r    <= a_idx_r;
    b_neg_r    <= vdist[37];
    b_beyond_r <= (mag > 38'(flh_pkg::HALF_PI_Q16));
    b_p_r      <= 32'(mag[16:0]) * 32'(SINE_TABLE_DEPTH);
    c_idx_r    <= b_idx_r;
    c_neg_r    <= b_neg_r;
    c_beyond_r <= b_beyond_r;
    c_prod_r   <= 64'(b_p_r) * RECIP;
    c_h_r      <= rd_data_r;
    d_idx_r    <= c_idx_r;
    d_h_r      <= c_h_r;
    d_f_r      <= c_neg_r ? -f_mag : f_mag;
    e_idx_r    <= d_idx_r;
    e_h_r      <= d_h_r;
    e_prod_r   <= disp_r * d_f_r;
  end

  // Height store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (clr_we) begin
      mem[addr_r] <= cfg.base_height;
    end else if (e_vld_r) begin
      mem[e_idx_r] <= new_h_sat;
    end
    rd_data_r <= mem[(state_r == ST_RD) ? AW'(cur_r.read_index) : a_idx_r];
  end

  // The grid walk only starts once the displacement is known.
  a_run_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> !div_busy)
    else $error("grid walk running while the divider is busy");

  // Vertex writes only happen while a fault is being applied.
  a_wr_fault: assert property (@(posedge clk) disable iff (!rst_n)
    e_vld_r |-> (state_r == ST_RUN || state_r == ST_DRAIN))
    else $error("vertex write outside fault processing");

  // A fault result reports the count one above the previous one, saturating.
  a_fault_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.valid && res_r.kind == flh_pkg::OP_FAULT) |->
      (res_r.faults == $past(fault_cnt_r) + 16'd1) ||
      ($past(fault_cnt_r) == 16'hFFFF && res_r.faults == 16'hFFFF))
    else $error("fault count out of step");

  // A clear result leaves the counter at zero.
  a_clr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.valid && res_r.kind == flh_pkg::OP_CLEAR) |-> fault_cnt_r == 16'd0)
    else $error("counter not cleared");

endmodule

// ===== hw/rtl/fault_line_heightmap_top.sv =====
// Fault-line heightmap generator. Items are taken whenever busy is low; a two-entry
// queue holds them while the engine works. Every item gives exactly one result,
// shown for one cycle on out_valid, which the receiver must take. A read passes
// through ST_RD and ST_RD2, an unknown operation is echoed from ST_IDLE, a clear
// writes base_height into every store entry (one store entry per cycle through
// the single write port), and a fault, while the displacement is still being
// interpolated, runs its setup states, waits out the bit-serial displacement
// division, takes one vertex per cycle, then drains the five-stage pipeline
// around the store. Once the fault count reaches iteration_count the division
// is skipped.
module fault_line_heightmap_top #(
  parameter int MAX_POINTS_W     = 64,
  parameter int MAX_POINTS_H     = 64,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_line_sin,
  input  logic [15:0] in_line_cos,
  input  logic [31:0] in_line_offset,
  input  logic [11:0] in_read_index,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [31:0] out_height_value,
  output logic [15:0] out_faults_done,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  flh_pkg::cfg_t    cfg_r;
  flh_pkg::item_t   item;
  flh_pkg::result_t res;
  logic             item_valid, item_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.points_w        <= 7'd64;
      cfg_r.points_h        <= 7'd64;
      cfg_r.point_spacing   <= 25'd65536;
      cfg_r.base_height     <= '0;
      cfg_r.disp_start      <= '0;
      cfg_r.disp_end        <= '0;
      cfg_r.iteration_count <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        flh_pkg::CFG_POINTS_W:   cfg_r.points_w        <= cfg_data[6:0];
        flh_pkg::CFG_POINTS_H:   cfg_r.points_h        <= cfg_data[6:0];
        flh_pkg::CFG_SPACING:    cfg_r.point_spacing   <= cfg_data[24:0];
        flh_pkg::CFG_BASE:       cfg_r.base_height     <= cfg_data;
        flh_pkg::CFG_DISP_START: cfg_r.disp_start      <= cfg_data;
        flh_pkg::CFG_DISP_END:   cfg_r.disp_end        <= cfg_data;
        flh_pkg::CFG_ITERATIONS: cfg_r.iteration_count <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  flh_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_line_sin    (in_line_sin),
    .in_line_cos    (in_line_cos),
    .in_line_offset (in_line_offset),
    .in_read_index  (in_read_index),
    .item_pop       (item_pop),
    .item_valid     (item_valid),
    .item           (item)
  );

  flh_back #(
    .MAX_POINTS_W     (MAX_POINTS_W),
    .MAX_POINTS_H     (MAX_POINTS_H),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res        (res)
  );

  // Result transfer.
  assign out_valid        = res.valid;
  assign out_kind         = res.kind;
  assign out_height_value = res.height;
  assign out_faults_done  = res.faults;

endmodule
